>>> rtl/core/obbfat_pkg.sv
`default_nettype none

package obbfat_pkg;

    // Default fixed-point formats
    localparam int AXIS_BITS_DEF   = 16;
    localparam int COORD_BITS_DEF  = 20;
    localparam int EXTENT_BITS_DEF = 16;

    // Number of candidate axes and the code for "no separating axis"
    localparam int         NUM_AXES  = 9;
    localparam logic [3:0] AXIS_NONE = 4'd9;

    // One box pair
    typedef struct packed {
        logic [47:0] box1_axis_x;
        logic [47:0] box1_axis_y;
        logic [47:0] box1_axis_z;
        logic [59:0] box1_center;
        logic [47:0] box1_half_size;
        logic [47:0] box2_axis_x;
        logic [47:0] box2_axis_y;
        logic [47:0] box2_axis_z;
        logic [59:0] box2_center;
        logic [47:0] box2_half_size;
    } obbfat_in_t;

    // One test result
    typedef struct packed {
        logic       collides;
        logic [3:0] separating_axis;
    } obbfat_out_t;

    // Load enables for the lane pipeline stages
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
        logic en5;
    } obbfat_stage_en_t;

endpackage

`default_nettype wire

>>> rtl/core/obbfat_lane.sv
`default_nettype none

// One candidate axis: projected centre distance against summed box radii.
module obbfat_lane
    import obbfat_pkg::*;
#(
    parameter int AXIS_BITS   = AXIS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire obbfat_stage_en_t              stage_en,
    input  wire logic signed [AXIS_BITS-1:0]   axis_vec [3],
    input  wire logic signed [COORD_BITS:0]    diff     [3],
    input  wire logic signed [AXIS_BITS-1:0]   cols     [6][3],
    input  wire logic        [EXTENT_BITS-1:0] half     [6],
    output logic                               separates
);

    localparam int FRAC   = AXIS_BITS - 2;
    localparam int PD_W   = AXIS_BITS + COORD_BITS + 1;
    localparam int DS_W   = PD_W + 2;
    localparam int DIST_W = DS_W + FRAC;
    localparam int PC_W   = 2 * AXIS_BITS;
    localparam int CS_W   = PC_W + 2;
    localparam int RT_W   = CS_W + EXTENT_BITS;
    localparam int RS_W   = RT_W + 3;
    localparam int CMP_W  = (DIST_W > RS_W) ? DIST_W : RS_W;

    logic signed [PD_W-1:0]        pd_reg [3];
    logic signed [PC_W-1:0]        pc_reg [6][3];
    logic        [EXTENT_BITS-1:0] h1_reg [6];
    logic        [DS_W-1:0]        dd_reg;
    logic        [CS_W-1:0]        dc_reg [6];
    logic        [EXTENT_BITS-1:0] h2_reg [6];
    logic        [DIST_W-1:0]      dist3_reg;
    logic        [RT_W-1:0]        rt_reg [6];
    logic        [DIST_W-1:0]      dist4_reg;
    logic        [RS_W-1:0]        rs_reg;
    logic                          sep_reg;

    logic signed [DS_W-1:0] dd_sum;
    logic signed [CS_W-1:0] dc_sum [6];
    logic        [DS_W-1:0] dd_mag;
    logic        [CS_W-1:0] dc_mag [6];
    logic        [RS_W-1:0] rs_next;

    // Stage 1: component products
    always_ff @(posedge aclk) begin
        if (stage_en.en1) begin
            for (int k = 0; k < 3; k++) begin
                pd_reg[k] <= $signed(axis_vec[k]) * $signed(diff[k]);
            end
            for (int c = 0; c < 6; c++) begin
                for (int k = 0; k < 3; k++) begin
                    pc_reg[c][k] <= $signed(axis_vec[k]) * $signed(cols[c][k]);
                end
                h1_reg[c] <= half[c];
            end
        end
    end

    // Dot product sums and magnitudes
    always_comb begin
        dd_sum = DS_W'(pd_reg[0]) + DS_W'(pd_reg[1]) + DS_W'(pd_reg[2]);
        dd_mag = dd_sum[DS_W-1] ? DS_W'(-dd_sum) : DS_W'(dd_sum);
        for (int c = 0; c < 6; c++) begin
            dc_sum[c] = CS_W'(pc_reg[c][0]) + CS_W'(pc_reg[c][1]) + CS_W'(pc_reg[c][2]);
            dc_mag[c] = dc_sum[c][CS_W-1] ? CS_W'(-dc_sum[c]) : CS_W'(dc_sum[c]);
        end
    end

    // Stage 2: absolute dot products
    always_ff @(posedge aclk) begin
        if (stage_en.en2) begin
            dd_reg <= dd_mag;
            for (int c = 0; c < 6; c++) begin
                dc_reg[c] <= dc_mag[c];
                h2_reg[c] <= h1_reg[c];
            end
        end
    end

    // Stage 3: radius terms, distance scaled to the common scale
    always_ff @(posedge aclk) begin
        if (stage_en.en3) begin
            dist3_reg <= DIST_W'(dd_reg) << FRAC;
            for (int c = 0; c < 6; c++) begin
                rt_reg[c] <= RT_W'(dc_reg[c]) * RT_W'(h2_reg[c]);
            end
        end
    end

    always_comb begin
        rs_next = '0;
        for (int c = 0; c < 6; c++) begin
            rs_next = rs_next + RS_W'(rt_reg[c]);
        end
    end

    // Stage 4: radius sum
    always_ff @(posedge aclk) begin
        if (stage_en.en4) begin
            dist4_reg <= dist3_reg;
            rs_reg    <= rs_next;
        end
    end

    // Stage 5: separation flag, touching counts as overlap
    always_ff @(posedge aclk) begin
        if (stage_en.en5) begin
            sep_reg <= CMP_W'(dist4_reg) > CMP_W'(rs_reg);
        end
    end

    assign separates = sep_reg;

endmodule

`default_nettype wire

>>> rtl/core/obb_face_axis_overlap_test.sv
`default_nettype none

// Oriented box overlap test on the nine face axes (world x/y/z, box 1 columns,
// box 2 columns). One box pair may be transferred every cycle while s_ready is high;
// each pair passes the input register, then five lane stages in each of the nine
// parallel axis lanes (a multiply-sum-multiply-sum-compare pipeline), then the output
// register. A stage holds only while the stage after it is full and held, so
// the input stalls only when every stage is full and m_ready is low. collides
// is 1 and separating_axis is 9 when no axis separates; otherwise
// separating_axis is the lowest separating axis. Edge-cross axes are not
// tested, so the result is conservative.
module obb_face_axis_overlap_test
    import obbfat_pkg::*;
#(
    parameter int AXIS_BITS   = AXIS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire obbfat_in_t  s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output obbfat_out_t      m_data
);

    localparam int FRAC  = AXIS_BITS - 2;
    localparam int AX_XW = 3 * AXIS_BITS + 64;
    localparam int CO_XW = 3 * COORD_BITS + 64;
    localparam int EX_XW = 3 * EXTENT_BITS + 64;

    logic [5:0]             valid_reg;
    logic [5:0]             valid_next;
    logic [5:0]             ready;
    logic                   out_valid_reg;
    obbfat_out_t            out_reg;
    obbfat_out_t            out_next;
    obbfat_stage_en_t       stage_en;

    logic signed [AXIS_BITS-1:0]   cols_in  [6][3];
    logic signed [COORD_BITS:0]    diff_in  [3];
    logic        [EXTENT_BITS-1:0] half_in  [6];
    logic signed [AXIS_BITS-1:0]   cols_reg [6][3];
    logic signed [COORD_BITS:0]    diff_reg [3];
    logic        [EXTENT_BITS-1:0] half_reg [6];
    logic signed [AXIS_BITS-1:0]   axes     [NUM_AXES][3];
    logic        [NUM_AXES-1:0]    sep;

    logic [AX_XW-1:0] ax_words [6];
    logic [CO_XW-1:0] c1_word, c2_word;
    logic [EX_XW-1:0] h1_word, h2_word;

    // Unpack the pair; high bits beyond a port read as zero
    always_comb begin
        ax_words[0] = AX_XW'(s_data.box1_axis_x);
        ax_words[1] = AX_XW'(s_data.box1_axis_y);
        ax_words[2] = AX_XW'(s_data.box1_axis_z);
        ax_words[3] = AX_XW'(s_data.box2_axis_x);
        ax_words[4] = AX_XW'(s_data.box2_axis_y);
        ax_words[5] = AX_XW'(s_data.box2_axis_z);
        c1_word     = CO_XW'(s_data.box1_center);
        c2_word     = CO_XW'(s_data.box2_center);
        h1_word     = EX_XW'(s_data.box1_half_size);
        h2_word     = EX_XW'(s_data.box2_half_size);
        for (int c = 0; c < 6; c++) begin
            for (int k = 0; k < 3; k++) begin
                cols_in[c][k] = ax_words[c][k*AXIS_BITS +: AXIS_BITS];
            end
        end
        for (int k = 0; k < 3; k++) begin
            diff_in[k] = $signed({c2_word[k*COORD_BITS+COORD_BITS-1],
                                  c2_word[k*COORD_BITS +: COORD_BITS]})
                       - $signed({c1_word[k*COORD_BITS+COORD_BITS-1],
                                  c1_word[k*COORD_BITS +: COORD_BITS]});
            half_in[k]     = h1_word[k*EXTENT_BITS +: EXTENT_BITS];
            half_in[3 + k] = h2_word[k*EXTENT_BITS +: EXTENT_BITS];
        end
    end

    // Stage 0: input register
    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            cols_reg <= cols_in;
            diff_reg <= diff_in;
            half_reg <= half_in;
        end
    end

    // Candidate axes: world unit axes, then both boxes' columns
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                axes[a][k]     = (a == k) ? AXIS_BITS'(1) << FRAC : '0;
                axes[3 + a][k] = cols_reg[a][k];
                axes[6 + a][k] = cols_reg[3 + a][k];
            end
        end
    end

    // Stall chain: a stage loads when empty or when it moves on
    always_comb begin
        ready[5] = !valid_reg[5] || !out_valid_reg || m_ready;
        for (int i = 4; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i + 1];
        end
        valid_next[0] = ready[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < 6; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i - 1] : valid_reg[i];
        end
        stage_en.en1 = ready[1];
        stage_en.en2 = ready[2];
        stage_en.en3 = ready[3];
        stage_en.en4 = ready[4];
        stage_en.en5 = ready[5];
    end

    assign s_ready = ready[0];

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        obbfat_lane #(
            .AXIS_BITS   (AXIS_BITS),
            .COORD_BITS  (COORD_BITS),
            .EXTENT_BITS (EXTENT_BITS)
        ) u_lane (
            .aclk      (aclk),
            .stage_en  (stage_en),
            .axis_vec  (axes[a]),
            .diff      (diff_reg),
            .cols      (cols_reg),
            .half      (half_reg),
            .separates (sep[a])
        );
    end

    // First separating axis wins
    always_comb begin
        out_next.separating_axis = AXIS_NONE;
        for (int a = NUM_AXES - 1; a >= 0; a--) begin
            if (sep[a]) begin
                out_next.separating_axis = 4'(a);
            end
        end
        out_next.collides = (sep == '0);
    end

    // Valid bits and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= valid_reg[5];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_reg[5] && (!out_valid_reg || m_ready)) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Result fields agree with each other
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.collides == (m_data.separating_axis == AXIS_NONE)))
        else $error("collides and separating_axis disagree");

    // Axis code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.separating_axis <= AXIS_NONE))
        else $error("separating_axis out of range");

    // Input back-pressure only when the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

    // Pipeline empty after reset
    assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire
